FILE: hw/rtl/audio_state_classifier_core_defines.svh
// assertion macros used by the checker file of the audio state classifier
`ifndef AUDIO_STATE_CLASSIFIER_CORE_DEFINES_SVH
`define AUDIO_STATE_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define ASC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asc check failed");

// next-cycle implication, held off during reset
`define ASC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asc check failed");

`endif

FILE: hw/rtl/asc_pkg.sv
// types, register indexes and state codes of the audio state classifier
`timescale 1ns / 1ps

package asc_pkg;

   localparam int CSR_INDEX_WIDTH = 3;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SILENCE_ENTER_TIME = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SILENCE_EXIT_TIME  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TEMPO_ENTER_LEVEL  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BEAT_ENTER_LEVEL   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TEMPO_EXIT_LEVEL   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BEAT_EXIT_LEVEL    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HYSTERESIS_TIME    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_DWELL_TIME     = 3'd7;

   // register reset values
   localparam logic [31:0] SILENCE_ENTER_TIME_RESET = 32'd1500;
   localparam logic [31:0] SILENCE_EXIT_TIME_RESET  = 32'd150;
   localparam logic [15:0] TEMPO_ENTER_LEVEL_RESET  = 16'd39322;
   localparam logic [15:0] BEAT_ENTER_LEVEL_RESET   = 16'd39322;
   localparam logic [15:0] TEMPO_EXIT_LEVEL_RESET   = 16'd26214;
   localparam logic [15:0] BEAT_EXIT_LEVEL_RESET    = 16'd26214;
   localparam logic [31:0] HYSTERESIS_TIME_RESET    = 32'd500;
   localparam logic [31:0] MIN_DWELL_TIME_RESET     = 32'd2000;

   // sound_state codes as seen on the result word
   localparam logic [1:0] SOUND_SILENCE = 2'd0;
   localparam logic [1:0] SOUND_DISORG  = 2'd1;
   localparam logic [1:0] SOUND_LOCKED  = 2'd2;

   typedef enum logic [2:0] {
      CLS_SILENCE = 3'b001,
      CLS_DISORG  = 3'b010,
      CLS_LOCKED  = 3'b100
   } class_state_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        is_silent;
      logic [15:0] tempo_level;
      logic [15:0] beat_level;
   } asc_req_type;

   typedef struct packed {
      logic [1:0] sound_state;
      logic       state_changed;
   } asc_rsp_type;

   function automatic logic [1:0] sound_code(input class_state_type state);
      logic [1:0] code;
      unique case (state)
         CLS_SILENCE: code = SOUND_SILENCE;
         CLS_DISORG:  code = SOUND_DISORG;
         CLS_LOCKED:  code = SOUND_LOCKED;
         default:     code = SOUND_SILENCE;
      endcase
      return code;
   endfunction

endpackage

FILE: hw/rtl/audio_state_classifier_core.sv
// audio state classifier: sorts each audio tick into silence, disorganized or beat locked.
// One result word comes out for every request word, in order. A word is taken into an
// input register, classified in one pass of compare-and-subtract logic against the held
// run and state timestamps, and lands in a result register that drives rsp_valid. A new
// word can be taken every cycle; the only
// stall is back-pressure from rsp_ready. All times are 32-bit millisecond stamps whose
// differences wrap modulo 2^32, and a stamp of zero in the held state means "unset".
// Silence is entered after silence_enter_time of continuous silence and left after
// silence_exit_time of sound; beat lock is entered when both confidences reach their
// enter levels and held while both stay at or above their exit levels. The reported
// state switches only once a differing candidate has persisted for hysteresis_time and
// the current state has lasted min_dwell_time. Registers may be written at any time
// the block is idle; csr_ready is always high.
`timescale 1ns / 1ps

module audio_state_classifier_core
   import asc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  asc_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output asc_rsp_type                rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_wdata
);

   // configuration registers
   logic [31:0] silence_enter_time_ff;
   logic [31:0] silence_exit_time_ff;
   logic [15:0] tempo_enter_level_ff;
   logic [15:0] beat_enter_level_ff;
   logic [15:0] tempo_exit_level_ff;
   logic [15:0] beat_exit_level_ff;
   logic [31:0] hysteresis_time_ff;
   logic [31:0] min_dwell_time_ff;

   // input and result stages
   logic        in_valid_ff;
   asc_req_type in_word_ff;
   logic        out_valid_ff;
   asc_rsp_type out_word_ff;

   // classifier state
   class_state_type cur_state_ff;
   class_state_type cur_state_in;
   class_state_type cand_state_ff;
   class_state_type cand_state_in;
   logic [31:0]     cand_since_ff;
   logic [31:0]     cand_since_in;
   logic [31:0]     entered_at_ff;
   logic [31:0]     entered_at_in;
   logic [31:0]     silent_since_ff;
   logic [31:0]     silent_since_in;
   logic [31:0]     sound_since_ff;
   logic [31:0]     sound_since_in;

   logic            advance;
   logic            req_fire;
   logic [31:0]     now;
   logic            silent;
   logic [31:0]     sound_run_ms;
   logic [31:0]     silent_run_ms;
   logic            released;
   logic            silence_reached;
   logic            enter_lock;
   logic            hold_lock;
   class_state_type instant;
   logic            changed;

   // handshake: the input stage drains whenever the result stage is free or emptying
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;
   assign csr_ready = 1'b1;

   assign now    = in_word_ff.now_ms;
   assign silent = in_word_ff.is_silent;

   // levels pass at or above threshold
   assign enter_lock = (in_word_ff.tempo_level >= tempo_enter_level_ff) &&
                       (in_word_ff.beat_level >= beat_enter_level_ff);
   assign hold_lock  = (in_word_ff.tempo_level >= tempo_exit_level_ff) &&
                       (in_word_ff.beat_level >= beat_exit_level_ff);

   always_comb begin
      // unset entry stamp picks up this tick's time
      entered_at_in = (entered_at_ff == 32'd0) ? now : entered_at_ff;

      // run starts: the run in progress keeps its start, the other one is cleared
      if (silent) begin
         silent_since_in = (silent_since_ff == 32'd0) ? now : silent_since_ff;
         sound_since_in  = 32'd0;
      end else begin
         sound_since_in  = (sound_since_ff == 32'd0) ? now : sound_since_ff;
         silent_since_in = 32'd0;
      end

      sound_run_ms  = now - sound_since_in;
      silent_run_ms = now - silent_since_in;

      released        = !silent && (sound_since_in != 32'd0) &&
                        (sound_run_ms >= silence_exit_time_ff);
      silence_reached = silent && (silent_since_in != 32'd0) &&
                        (silent_run_ms >= silence_enter_time_ff);

      // instant state, highest priority first
      if (silence_reached) begin
         instant = CLS_SILENCE;
      end else if (cur_state_ff == CLS_SILENCE && !released) begin
         instant = CLS_SILENCE;
      end else if (!silent && enter_lock) begin
         instant = CLS_LOCKED;
      end else if (cur_state_ff == CLS_LOCKED && hold_lock) begin
         instant = CLS_LOCKED;
      end else if (cur_state_ff == CLS_SILENCE && silent) begin
         instant = CLS_SILENCE;
      end else begin
         instant = CLS_DISORG;
      end

      // candidate tracking and the hysteresis / dwell gate
      cur_state_in = cur_state_ff;
      if (instant != cur_state_ff) begin
         if (instant != cand_state_ff) begin
            cand_state_in = instant;
            cand_since_in = now;
         end else begin
            cand_state_in = cand_state_ff;
            cand_since_in = cand_since_ff;
         end
         if (((now - cand_since_in) >= hysteresis_time_ff) &&
             ((now - entered_at_in) >= min_dwell_time_ff)) begin
            cur_state_in = instant;
         end
      end else begin
         cand_state_in = cur_state_ff;
         cand_since_in = now;
      end

      changed = (cur_state_in != cur_state_ff);
      if (changed) begin
         entered_at_in = now;
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload stages, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_word_ff.sound_state   <= sound_code(cur_state_in);
         out_word_ff.state_changed <= changed;
      end
   end

   // classifier state moves only when a word passes through the logic
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_state_ff    <= CLS_SILENCE;
         cand_state_ff   <= CLS_SILENCE;
         cand_since_ff   <= 32'd0;
         entered_at_ff   <= 32'd0;
         silent_since_ff <= 32'd0;
         sound_since_ff  <= 32'd0;
      end else if (advance) begin
         cur_state_ff    <= cur_state_in;
         cand_state_ff   <= cand_state_in;
         cand_since_ff   <= cand_since_in;
         entered_at_ff   <= entered_at_in;
         silent_since_ff <= silent_since_in;
         sound_since_ff  <= sound_since_in;
      end
   end

   // configuration writes, 16-bit levels keep the low half of the data
   always_ff @(posedge clock) begin
      if (reset) begin
         silence_enter_time_ff <= SILENCE_ENTER_TIME_RESET;
         silence_exit_time_ff  <= SILENCE_EXIT_TIME_RESET;
         tempo_enter_level_ff  <= TEMPO_ENTER_LEVEL_RESET;
         beat_enter_level_ff   <= BEAT_ENTER_LEVEL_RESET;
         tempo_exit_level_ff   <= TEMPO_EXIT_LEVEL_RESET;
         beat_exit_level_ff    <= BEAT_EXIT_LEVEL_RESET;
         hysteresis_time_ff    <= HYSTERESIS_TIME_RESET;
         min_dwell_time_ff     <= MIN_DWELL_TIME_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SILENCE_ENTER_TIME: silence_enter_time_ff <= csr_wdata;
            REG_SILENCE_EXIT_TIME:  silence_exit_time_ff  <= csr_wdata;
            REG_TEMPO_ENTER_LEVEL:  tempo_enter_level_ff  <= csr_wdata[15:0];
            REG_BEAT_ENTER_LEVEL:   beat_enter_level_ff   <= csr_wdata[15:0];
            REG_TEMPO_EXIT_LEVEL:   tempo_exit_level_ff   <= csr_wdata[15:0];
            REG_BEAT_EXIT_LEVEL:    beat_exit_level_ff    <= csr_wdata[15:0];
            REG_HYSTERESIS_TIME:    hysteresis_time_ff    <= csr_wdata;
            REG_MIN_DWELL_TIME:     min_dwell_time_ff     <= csr_wdata;
            default:                min_dwell_time_ff     <= min_dwell_time_ff;
         endcase
      end
   end

endmodule

FILE: hw/rtl/asc_checker.sv
// port-level checker for the audio state classifier, bound to the top level
`timescale 1ns / 1ps
`include "audio_state_classifier_core_defines.svh"

module asc_checker
   import asc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input asc_rsp_type rsp_data
);

   logic [1:0] last_state_ff;
   logic [1:0] last_state_in;
   logic       rsp_stall;
   logic       changed_flag;
   logic       same_as_last;

   // state last handed out; the block resets into silence
   assign last_state_in = (rsp_valid && rsp_ready) ? rsp_data.sound_state : last_state_ff;
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign changed_flag  = rsp_data.state_changed;
   assign same_as_last  = (rsp_data.sound_state == last_state_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_state_ff <= SOUND_SILENCE;
      end else begin
         last_state_ff <= last_state_in;
      end
   end

   `ASC_ASSERT_NEXT(rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `ASC_ASSERT_NOW(no_change_keeps_state, clock, reset, rsp_valid && !changed_flag, same_as_last)
   `ASC_ASSERT_NOW(change_moves_state, clock, reset, rsp_valid && changed_flag, !same_as_last)
   `ASC_ASSERT_NOW(empty_output_takes_input, clock, reset, !rsp_valid, req_ready)

endmodule

bind audio_state_classifier_core asc_checker u_asc_checker (.*);

FILE: tb/sv/tb_audio_state_classifier_core.sv
// self-checking testbench for the audio state classifier core, prediction against a local model
`timescale 1ns / 1ps

module tb_audio_state_classifier_core;
   import asc_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT = 500000;
   // receiver hold-off long enough to fill the two internal stages and stall req_ready
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   asc_req_type                req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   asc_rsp_type                rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                csr_wdata = '0;

   // register copies, masked to their widths as the block keeps them
   logic [31:0] reg_silence_enter;
   logic [31:0] reg_silence_exit;
   logic [15:0] reg_tempo_enter;
   logic [15:0] reg_beat_enter;
   logic [15:0] reg_tempo_exit;
   logic [15:0] reg_beat_exit;
   logic [31:0] reg_hysteresis;
   logic [31:0] reg_min_dwell;

   // predicted classifier state; a zero timestamp means unset
   logic [1:0]  pred_state;
   logic [1:0]  pred_candidate;
   logic [31:0] pred_candidate_since;
   logic [31:0] pred_entered_at;
   logic [31:0] pred_silent_since;
   logic [31:0] pred_sound_since;

   // predicted result words, oldest first
   asc_rsp_type state_predictions[$];

   int          mismatches = 0;
   int          results_checked = 0;
   int          ticks_sent = 0;
   int          csr_writes = 0;
   int          settings_used = 0;
   int          cycle_count = 0;

   // sender side state
   logic [31:0] track_ms = '0;
   logic        no_idle = 1'b0;

   // receiver hold-off request: the test bumps hold_asked, the receiver counts the stall
   int          hold_asked = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          ready_gap = 0;

   audio_state_classifier_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // wrapped millisecond difference
   function automatic logic [31:0] span_ms(input logic [31:0] later, input logic [31:0] since);
      return later - since;
   endfunction

   // one tick through the classifier: run tracking, instant state, hysteresis and dwell
   function automatic asc_rsp_type classify_tick(input asc_req_type t);
      asc_rsp_type word;
      logic [1:0]  instant;
      logic [1:0]  next_state;
      logic        released;
      if (pred_entered_at == '0) pred_entered_at = t.now_ms;
      // run starts; a run begun at time zero still looks unset next tick
      if (t.is_silent) begin
         if (pred_silent_since == '0) pred_silent_since = t.now_ms;
         pred_sound_since = '0;
      end else begin
         if (pred_sound_since == '0) pred_sound_since = t.now_ms;
         pred_silent_since = '0;
      end
      released = !t.is_silent && pred_sound_since != '0 &&
                 span_ms(t.now_ms, pred_sound_since) >= reg_silence_exit;
      // instant state, in priority order
      if (t.is_silent && pred_silent_since != '0 &&
          span_ms(t.now_ms, pred_silent_since) >= reg_silence_enter)
         instant = SOUND_SILENCE;
      else if (pred_state == SOUND_SILENCE && !released)
         instant = SOUND_SILENCE;
      else if (!t.is_silent && t.tempo_level >= reg_tempo_enter &&
               t.beat_level >= reg_beat_enter)
         instant = SOUND_LOCKED;
      else if (pred_state == SOUND_LOCKED && t.tempo_level >= reg_tempo_exit &&
               t.beat_level >= reg_beat_exit)
         instant = SOUND_LOCKED;
      else if (pred_state == SOUND_SILENCE && t.is_silent)
         instant = SOUND_SILENCE;
      else
         instant = SOUND_DISORG;
      // candidate must persist and the current state must have dwelt long enough
      next_state = pred_state;
      if (instant != pred_state) begin
         if (instant != pred_candidate) begin
            pred_candidate = instant;
            pred_candidate_since = t.now_ms;
         end
         if (span_ms(t.now_ms, pred_candidate_since) >= reg_hysteresis &&
             span_ms(t.now_ms, pred_entered_at) >= reg_min_dwell)
            next_state = instant;
      end else begin
         pred_candidate = pred_state;
         pred_candidate_since = t.now_ms;
      end
      word.state_changed = 1'b0;
      if (next_state != pred_state) begin
         pred_state = next_state;
         pred_entered_at = t.now_ms;
         word.state_changed = 1'b1;
      end
      word.sound_state = pred_state;
      return word;
   endfunction

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
   endtask

   // every result word taken by the receiver is matched against the oldest prediction
   always @(posedge clock) begin : check_results
      asc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (state_predictions.size() == 0) begin
            report_mismatch("unexpected result word, sound_state", rsp_data.sound_state, 0);
         end else begin
            want = state_predictions.pop_front();
            if (rsp_data.sound_state !== want.sound_state)
               report_mismatch("sound_state", rsp_data.sound_state, want.sound_state);
            if (rsp_data.state_changed !== want.state_changed)
               report_mismatch("state_changed", rsp_data.state_changed, want.state_changed);
            results_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // idling on both sides
   // ------------------------------------------------------------------

   // mostly back to back, sometimes a short gap, rarely a long one
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: random stalls, plus a long counted hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (ready_gap > 0) begin
         rsp_ready <= 1'b0;
         ready_gap--;
      end else if (no_idle || $urandom_range(0, 99) < 75) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         ready_gap = pick_gap();
      end
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, state_predictions.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // offer one tick word, hold it until taken, predict it, then maybe idle
   task automatic offer(input logic [31:0] now, input logic silent,
                        input logic [15:0] tempo, input logic [15:0] beat);
      asc_req_type t;
      int          gap;
      t.now_ms = now;
      t.is_silent = silent;
      t.tempo_level = tempo;
      t.beat_level = beat;
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      state_predictions.push_back(classify_tick(t));
      ticks_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender stops and waits for every predicted word, then the pipeline latency
   task automatic drain_results();
      req_valid <= 1'b0;
      while (state_predictions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         REG_SILENCE_ENTER_TIME: reg_silence_enter = value;
         REG_SILENCE_EXIT_TIME:  reg_silence_exit = value;
         REG_TEMPO_ENTER_LEVEL:  reg_tempo_enter = value[15:0];
         REG_BEAT_ENTER_LEVEL:   reg_beat_enter = value[15:0];
         REG_TEMPO_EXIT_LEVEL:   reg_tempo_exit = value[15:0];
         REG_BEAT_EXIT_LEVEL:    reg_beat_exit = value[15:0];
         REG_HYSTERESIS_TIME:    reg_hysteresis = value;
         REG_MIN_DWELL_TIME:     reg_min_dwell = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   // full register set, written only once the block has gone idle
   task automatic write_regs(input logic [31:0] sil_enter, input logic [31:0] sil_exit,
                             input logic [31:0] tempo_enter, input logic [31:0] beat_enter,
                             input logic [31:0] tempo_exit, input logic [31:0] beat_exit,
                             input logic [31:0] hyst, input logic [31:0] dwell);
      drain_results();
      csr_write(REG_SILENCE_ENTER_TIME, sil_enter);
      csr_write(REG_SILENCE_EXIT_TIME, sil_exit);
      csr_write(REG_TEMPO_ENTER_LEVEL, tempo_enter);
      csr_write(REG_BEAT_ENTER_LEVEL, beat_enter);
      csr_write(REG_TEMPO_EXIT_LEVEL, tempo_exit);
      csr_write(REG_BEAT_EXIT_LEVEL, beat_exit);
      csr_write(REG_HYSTERESIS_TIME, hyst);
      csr_write(REG_MIN_DWELL_TIME, dwell);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // ------------------------------------------------------------------
   // random tick streams
   // ------------------------------------------------------------------

   // a level a few counts either side of a threshold
   function automatic logic [15:0] near_level(input logic [15:0] thr);
      int v;
      v = int'(thr) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return 16'(v);
   endfunction

   // level for one tick, shaped by the kind of run in progress
   function automatic logic [15:0] run_level(input int kind, input logic [15:0] enter_thr,
                                             input logic [15:0] exit_thr);
      case (kind)
         0: return 16'($urandom_range(enter_thr, 16'hFFFF));
         1: return near_level($urandom_range(0, 1) ? enter_thr : exit_thr);
         2: return 16'($urandom_range(0, exit_thr));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // mostly runs of silence or sound with a steadily advancing clock,
   // with zero stamps, wrap jumps and fully random words mixed in
   task automatic run_random_ticks(input int count, input int step_max);
      int   k;
      int   roll;
      int   run_left;
      int   kind;
      logic silent_run;
      run_left = 0;
      kind = 0;
      silent_run = 1'b0;
      for (k = 0; k < count; k++) begin
         if (run_left == 0) begin
            silent_run = 1'($urandom_range(0, 1));
            run_left = $urandom_range(1, 25);
            kind = $urandom_range(0, 3);
         end
         run_left--;
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            // noise word, every field at random
            offer($urandom, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
         end else begin
            if (roll < 9) track_ms = '0;
            else if (roll < 11) track_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * step_max);
            else if (roll < 13) track_ms = $urandom;
            else track_ms = track_ms + $urandom_range(0, step_max);
            offer(track_ms, silent_run, run_level(kind, reg_tempo_enter, reg_tempo_exit),
                  run_level(kind, reg_beat_enter, reg_beat_exit));
         end
      end
   endtask

   // time setting drawn from the extremes, a small range or anywhere
   function automatic logic [31:0] pick_time();
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 500);
         default: return $urandom;
      endcase
   endfunction

   // level setting with junk in the upper half, which the block must drop
   function automatic logic [31:0] pick_level_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 3))
         0: w[15:0] = 16'h0000;
         1: w[15:0] = 16'hFFFF;
         default: ;
      endcase
      return w;
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // hand-built walk under the reset settings: zero stamps, exit threshold
   // release, lock entry and hold at exact levels, dwell, silence entry, wrap
   task automatic test_directed_walk();
      offer(32'd0, 1'b1, 16'h0000, 16'h0000);
      offer(32'd0, 1'b0, 16'hFFFF, 16'hFFFF);
      offer(32'd100, 1'b0, 16'hFFFF, 16'hFFFF);
      offer(32'd250, 1'b0, 16'hFFFF, 16'hFFFF);
      offer(32'd800, 1'b0, 16'hFFFF, 16'hFFFF);
      offer(32'd2100, 1'b0, 16'hFFFF, 16'hFFFF);
      offer(32'd2300, 1'b0, TEMPO_EXIT_LEVEL_RESET, BEAT_EXIT_LEVEL_RESET);
      offer(32'd2400, 1'b0, TEMPO_EXIT_LEVEL_RESET - 16'd1, 16'hFFFF);
      offer(32'd2500, 1'b0, TEMPO_ENTER_LEVEL_RESET, BEAT_ENTER_LEVEL_RESET);
      offer(32'd3000, 1'b0, 16'h0000, 16'h0000);
      offer(32'd3600, 1'b0, 16'h0000, 16'h0000);
      offer(32'd4200, 1'b0, 16'h0000, 16'h0000);
      offer(32'd4300, 1'b1, 16'h0000, 16'h0000);
      offer(32'd5000, 1'b1, 16'hFFFF, 16'hFFFF);
      offer(32'd5900, 1'b1, 16'h0000, 16'h0000);
      offer(32'd6500, 1'b1, 16'h0000, 16'h0000);
      offer(32'd6600, 1'b0, 16'hFFFF, 16'hFFFF);
      offer(32'd6700, 1'b0, 16'hFFFF, 16'hFFFF);
      offer(32'd6750, 1'b0, 16'hFFFF, 16'hFFFF);
      offer(32'hFFFF_FF00, 1'b0, 16'hFFFF, 16'hFFFF);
      offer(32'h0000_0200, 1'b0, 16'hFFFF, 16'hFFFF);
      offer(32'h0000_0400, 1'b0, 16'hFFFF, 16'hFFFF);
      track_ms = 32'h0000_0400;
   endtask

   task automatic test_reset_settings();
      run_random_ticks(300, 400);
   endtask

   // short times so switches happen every few ticks; first half with no idling
   task automatic test_fast_times();
      int p;
      for (p = 0; p < 2; p++) begin
         write_regs($urandom_range(0, 400), $urandom_range(0, 150),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 150), $urandom_range(0, 300));
         no_idle = (p == 0);
         run_random_ticks(175, 80);
      end
      no_idle = 1'b0;
   endtask

   // every time and level at zero: any differing state is taken at once
   task automatic test_zero_settings();
      write_regs('0, '0, '0, '0, '0, '0, '0, '0);
      run_random_ticks(100, 50);
   endtask

   // every time and level at its maximum: switching needs the full wrap
   task automatic test_max_settings();
      write_regs('1, '1, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, '1, '1);
      run_random_ticks(100, 400);
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      write_regs(32'd200, 32'd40, 32'd30000, 32'd30000, 32'd20000, 32'd20000,
                 32'd30, 32'd60);
      hold_asked++;
      no_idle = 1'b1;
      run_random_ticks(60, 40);
      no_idle = 1'b0;
      drain_results();
      run_random_ticks(40, 40);
   endtask

   // registers drawn from extremes and random values, levels with upper junk
   task automatic test_mixed_settings();
      int p;
      for (p = 0; p < 4; p++) begin
         write_regs(pick_time(), pick_time(), pick_level_word(), pick_level_word(),
                    pick_level_word(), pick_level_word(), pick_time(), pick_time());
         run_random_ticks(60, 300);
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      // model registers and state start at their reset values
      reg_silence_enter = SILENCE_ENTER_TIME_RESET;
      reg_silence_exit = SILENCE_EXIT_TIME_RESET;
      reg_tempo_enter = TEMPO_ENTER_LEVEL_RESET;
      reg_beat_enter = BEAT_ENTER_LEVEL_RESET;
      reg_tempo_exit = TEMPO_EXIT_LEVEL_RESET;
      reg_beat_exit = BEAT_EXIT_LEVEL_RESET;
      reg_hysteresis = HYSTERESIS_TIME_RESET;
      reg_min_dwell = MIN_DWELL_TIME_RESET;
      pred_state = SOUND_SILENCE;
      pred_candidate = SOUND_SILENCE;
      pred_candidate_since = '0;
      pred_entered_at = '0;
      pred_silent_since = '0;
      pred_sound_since = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_walk();
      test_reset_settings();
      test_fast_times();
      test_zero_settings();
      test_max_settings();
      test_backpressure();
      test_mixed_settings();

      // settle, then wait on to catch any stray result word
      drain_results();
      repeat (8) @(posedge clock);

      $display("covered %0d ticks and %0d checked results over %0d register settings",
               ticks_sent, results_checked, settings_used);
      $display("%0d register writes, %0d mismatches, %0d cycles",
               csr_writes, mismatches, cycle_count);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
